/* src/rtph264_pkg.sv */
`timescale 1ns / 1ps

package rtph264_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_SSRC       = 3'd0;
    localparam logic [2:0] REG_START_SEQ  = 3'd1;
    localparam logic [2:0] REG_START_TS   = 3'd2;
    localparam logic [2:0] REG_TS_STEP    = 3'd3;
    localparam logic [2:0] REG_SINGLE_MAX = 3'd4;
    localparam logic [2:0] REG_FRAG_MAX   = 3'd5;

    // Configuration reset values
    localparam logic [31:0] TS_STEP_RESET    = 32'd3600;
    localparam logic [15:0] SINGLE_MAX_RESET = 16'd1448;
    localparam logic [15:0] FRAG_MAX_RESET   = 16'd1446;

    // RTP and FU-A header constants
    localparam logic [7:0] RTP_VER_BYTE  = 8'h80;
    localparam logic [6:0] RTP_PT        = 7'd96;
    localparam logic [7:0] FU_NRI_MASK   = 8'hE0;
    localparam logic [7:0] FU_A_TYPE     = 8'd28;
    localparam logic [4:0] NAL_TYPE_BITS = 5'h1F;

    // Byte positions within one packet sequence
    localparam logic [3:0] IDX_FIRST   = 4'd0;
    localparam logic [3:0] IDX_FU_IND  = 4'd12;
    localparam logic [3:0] IDX_FU_HDR  = 4'd13;
    localparam logic [3:0] SINGLE_LAST = 4'd12;
    localparam logic [3:0] FU_LAST     = 4'd14;
    localparam logic [3:0] PLAIN_START = 4'd14;

    // One pending emission: header fields snapshot plus the payload byte
    typedef struct packed {
        logic [3:0]  idx;
        logic [3:0]  last;
        logic        marker;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
        logic [7:0]  data;
        logic        pkt_end;
    } job_t;

endpackage

/* src/rtp_h264_nal_packetizer.sv */
`timescale 1ns / 1ps
// Channel   | Handshake             | Payload
// ----------+-----------------------+--------------------------------------
// input     | in_valid / in_ready   | nal_byte, nal_first, nal_length
// output    | out_valid / out_ready | packet_byte, packet_start, packet_end
// config    | cfg_we                | cfg_index, cfg_data
//
// Each input transaction is decoded into a job register that feeds one packet
// byte per cycle, unless stalled, to the output register. A payload byte gives
// one byte; a byte opening a packet gives 13 (single NAL) or 15 (FU-A), led by
// the 12 RTP header bytes. A NAL header byte in fragment mode is only stored.
// Reset clears all control state and loads the configuration defaults.
// out_ready low stalls the job register and, through in_ready, the input.

module rtp_h264_nal_packetizer
    import rtph264_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  nal_byte,
    input  logic        nal_first,
    input  logic [15:0] nal_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  packet_byte,
    output logic        packet_start,
    output logic        packet_end
);

    // Configuration registers
    logic [31:0] ssrc_reg;
    logic [31:0] ts_step_reg,    ts_step_next;
    logic [15:0] single_max_reg, single_max_next;
    logic [15:0] frag_max_reg,   frag_max_next;
    logic [31:0] ssrc_next;

    // Packetizer state
    logic [15:0] seq_count_reg,  seq_count_next;
    logic [31:0] run_ts_reg,     run_ts_next;
    logic        frag_mode_reg,  frag_mode_next;
    logic [7:0]  saved_hdr_reg,  saved_hdr_next;
    logic [15:0] pay_rem_reg,    pay_rem_next;
    logic [15:0] frag_rem_reg,   frag_rem_next;
    logic        first_frag_reg, first_frag_next;

    // Job and output registers
    logic        job_valid_reg, job_valid_next;
    job_t        job_reg, job_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg,  out_byte_next;
    logic        out_start_reg, out_start_next;
    logic        out_end_reg,   out_end_next;

    logic        accept;
    logic        out_load;
    logic        job_at_last;
    logic [7:0]  sel_byte;

    // Decode helpers
    logic [15:0] len_eff;
    logic [15:0] pay_first;
    logic        is_single;
    logic [15:0] fmax;
    logic [15:0] frag_size;
    logic [15:0] pay_dec;
    logic [15:0] fr_eff;
    logic [15:0] fr_dec;
    logic [7:0]  fu_hdr;
    logic [31:0] ts_adv;

    assign job_at_last = (job_reg.idx == job_reg.last);
    assign out_load    = job_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready    = !job_valid_reg || (out_load && job_at_last);
    assign accept      = in_valid && in_ready;

    // Decode the incoming byte against the current state
    assign len_eff   = (nal_length == 16'd0) ? 16'd1 : nal_length;
    assign pay_first = len_eff - 16'd1;
    assign is_single = (len_eff <= single_max_reg);
    assign ts_adv    = run_ts_reg + ts_step_reg;
    assign fmax      = (frag_max_reg == 16'd0) ? 16'd1 : frag_max_reg;
    assign frag_size = (pay_rem_reg < fmax) ? pay_rem_reg : fmax;
    assign pay_dec   = pay_rem_reg - 16'd1;
    assign fr_eff    = (frag_rem_reg == 16'd0) ? frag_size : frag_rem_reg;
    assign fr_dec    = fr_eff - 16'd1;
    assign fu_hdr    = {first_frag_reg, !first_frag_reg && (frag_size == pay_rem_reg),
                        1'b0, saved_hdr_reg[4:0] & NAL_TYPE_BITS};

    // Pick the byte at the current job position
    always_comb
    begin
        sel_byte = 8'h00;
        if (job_at_last)
        begin
            sel_byte = job_reg.data;
        end
        else
        begin
            unique case (job_reg.idx)
                4'd0:       sel_byte = RTP_VER_BYTE;
                4'd1:       sel_byte = {job_reg.marker, RTP_PT};
                4'd2:       sel_byte = job_reg.seq[15:8];
                4'd3:       sel_byte = job_reg.seq[7:0];
                4'd4:       sel_byte = job_reg.ts[31:24];
                4'd5:       sel_byte = job_reg.ts[23:16];
                4'd6:       sel_byte = job_reg.ts[15:8];
                4'd7:       sel_byte = job_reg.ts[7:0];
                4'd8:       sel_byte = ssrc_reg[31:24];
                4'd9:       sel_byte = ssrc_reg[23:16];
                4'd10:      sel_byte = ssrc_reg[15:8];
                4'd11:      sel_byte = ssrc_reg[7:0];
                IDX_FU_IND: sel_byte = job_reg.fu_ind;
                IDX_FU_HDR: sel_byte = job_reg.fu_hdr;
                default:    sel_byte = job_reg.data;
            endcase
        end
    end

    // Next state: configuration writes, transaction decode, byte emission
    always_comb
    begin
        ssrc_next       = ssrc_reg;
        ts_step_next    = ts_step_reg;
        single_max_next = single_max_reg;
        frag_max_next   = frag_max_reg;
        seq_count_next  = seq_count_reg;
        run_ts_next     = run_ts_reg;
        frag_mode_next  = frag_mode_reg;
        saved_hdr_next  = saved_hdr_reg;
        pay_rem_next    = pay_rem_reg;
        frag_rem_next   = frag_rem_reg;
        first_frag_next = first_frag_reg;
        job_valid_next  = job_valid_reg;
        job_next        = job_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;

        // Drop the output once taken, then refill from the job
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = sel_byte;
            out_start_next = (job_reg.idx == IDX_FIRST);
            out_end_next   = job_at_last && job_reg.pkt_end;
            if (job_at_last)
            begin
                job_valid_next = 1'b0;
            end
            else
            begin
                job_next.idx = job_reg.idx + 4'd1;
            end
        end

        // Configuration writes must arrive only while idle; the block itself does not enforce this
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SSRC:       ssrc_next       = cfg_data;
                REG_START_SEQ:  seq_count_next  = cfg_data[15:0];
                REG_START_TS:   run_ts_next     = cfg_data;
                REG_TS_STEP:    ts_step_next    = cfg_data;
                REG_SINGLE_MAX: single_max_next = cfg_data[15:0];
                REG_FRAG_MAX:   frag_max_next   = cfg_data[15:0];
                default:        ;
            endcase
        end

        // Decode an accepted transaction
        if (accept)
        begin
            job_next.seq    = seq_count_reg;
            job_next.data   = nal_byte;
            job_next.fu_ind = (saved_hdr_reg & FU_NRI_MASK) | FU_A_TYPE;
            job_next.fu_hdr = fu_hdr;
            if (nal_first)
            begin
                run_ts_next   = ts_adv;
                frag_rem_next = 16'd0;
                pay_rem_next  = pay_first;
                if (is_single)
                begin
                    frag_mode_next   = 1'b0;
                    first_frag_next  = 1'b0;
                    seq_count_next   = seq_count_reg + 16'd1;
                    job_valid_next   = 1'b1;
                    job_next.idx     = IDX_FIRST;
                    job_next.last    = SINGLE_LAST;
                    job_next.marker  = 1'b1;
                    job_next.ts      = ts_adv;
                    job_next.pkt_end = (pay_first == 16'd0);
                end
                else
                begin
                    frag_mode_next  = 1'b1;
                    saved_hdr_next  = nal_byte;
                    first_frag_next = 1'b1;
                end
            end
            else if (pay_rem_reg != 16'd0)
            begin
                pay_rem_next   = pay_dec;
                job_valid_next = 1'b1;
                if (!frag_mode_reg)
                begin
                    job_next.idx     = PLAIN_START;
                    job_next.last    = PLAIN_START;
                    job_next.pkt_end = (pay_dec == 16'd0);
                end
                else
                begin
                    frag_rem_next    = fr_dec;
                    job_next.pkt_end = (fr_dec == 16'd0);
                    if (frag_rem_reg == 16'd0)
                    begin
                        // Open a new FU-A fragment
                        seq_count_next  = seq_count_reg + 16'd1;
                        first_frag_next = 1'b0;
                        job_next.idx    = IDX_FIRST;
                        job_next.last   = FU_LAST;
                        job_next.marker = 1'b0;
                        job_next.ts     = run_ts_reg;
                    end
                    else
                    begin
                        job_next.idx  = PLAIN_START;
                        job_next.last = PLAIN_START;
                    end
                end
            end
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssrc_reg       <= 32'd0;
            ts_step_reg    <= TS_STEP_RESET;
            single_max_reg <= SINGLE_MAX_RESET;
            frag_max_reg   <= FRAG_MAX_RESET;
            seq_count_reg  <= 16'd0;
            run_ts_reg     <= 32'd0;
            frag_mode_reg  <= 1'b0;
            saved_hdr_reg  <= 8'd0;
            pay_rem_reg    <= 16'd0;
            frag_rem_reg   <= 16'd0;
            first_frag_reg <= 1'b0;
            job_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ssrc_reg       <= ssrc_next;
            ts_step_reg    <= ts_step_next;
            single_max_reg <= single_max_next;
            frag_max_reg   <= frag_max_next;
            seq_count_reg  <= seq_count_next;
            run_ts_reg     <= run_ts_next;
            frag_mode_reg  <= frag_mode_next;
            saved_hdr_reg  <= saved_hdr_next;
            pay_rem_reg    <= pay_rem_next;
            frag_rem_reg   <= frag_rem_next;
            first_frag_reg <= first_frag_next;
            job_valid_reg  <= job_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        out_byte_reg  <= out_byte_next;
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
    end

    assign out_valid    = out_valid_reg;
    assign packet_byte  = out_byte_reg;
    assign packet_start = out_start_reg;
    assign packet_end   = out_end_reg;

endmodule

/* src/rtph264_checker.sv */
`timescale 1ns / 1ps

module rtph264_checker
    import rtph264_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] packet_byte,
    input logic       packet_start,
    input logic       packet_end
);

    // Hold the output idle during reset
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // Hold a stalled output transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(packet_byte)
        && $stable(packet_start) && $stable(packet_end))
        else $error("stalled output changed");

    // Every packet is longer than one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(packet_start && packet_end))
        else $error("packet start and end on one byte");

    // A packet opens with the RTP version byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_start |-> packet_byte == RTP_VER_BYTE)
        else $error("packet start is not a version byte");

    // The byte after a packet start belongs to the same header
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && packet_start |=> !(out_valid && packet_start))
        else $error("two packet starts in a row");

endmodule

bind rtp_h264_nal_packetizer rtph264_checker u_rtph264_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .packet_byte  (packet_byte),
    .packet_start (packet_start),
    .packet_end   (packet_end)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import rtph264_pkg::*;

    // Indexes past the register map: writes there must be ignored
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    // FU header flag bits
    localparam logic [7:0] FU_S_FLAG = 8'h80;
    localparam logic [7:0] FU_E_FLAG = 8'h40;

    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_CYCLES  = 32;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 100;

    typedef struct packed {
        logic [7:0] data;
        logic       sop;
        logic       eop;
    } pkt_byte_t;

    // Tracks packetizer state and holds the packet bytes still owed by the block
    class rtp_packet_tracker;
        logic [31:0] ssrc;
        logic [31:0] ts_step;
        logic [15:0] single_max;
        logic [15:0] frag_max;
        logic [15:0] seq_count;
        logic [31:0] cur_ts;
        logic        frag_mode;
        logic [7:0]  nal_hdr;
        logic [15:0] payload_left;
        logic [15:0] frag_left;
        logic        first_frag;
        pkt_byte_t   owed[$];
        int          fails;

        function new();
            ssrc         = '0;
            ts_step      = TS_STEP_RESET;
            single_max   = SINGLE_MAX_RESET;
            frag_max     = FRAG_MAX_RESET;
            seq_count    = '0;
            cur_ts       = '0;
            frag_mode    = 1'b0;
            nal_hdr      = '0;
            payload_left = '0;
            frag_left    = '0;
            first_frag   = 1'b0;
            fails        = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_SSRC:       ssrc = val;
                REG_START_SEQ:  seq_count = val[15:0];
                REG_START_TS:   cur_ts = val;
                REG_TS_STEP:    ts_step = val;
                REG_SINGLE_MAX: single_max = val[15:0];
                REG_FRAG_MAX:   frag_max = val[15:0];
                default:        ;
            endcase
        endfunction

        function void owe(logic [7:0] d, logic s, logic e);
            pkt_byte_t pb;
            pb.data = d;
            pb.sop  = s;
            pb.eop  = e;
            owed.push_back(pb);
        endfunction

        // Queue the 12 RTP header bytes and advance the sequence number
        function void owe_header(logic marker);
            logic [15:0] sq;
            sq = seq_count;
            seq_count = seq_count + 16'd1;
            owe(RTP_VER_BYTE, 1'b1, 1'b0);
            owe({marker, RTP_PT}, 1'b0, 1'b0);
            owe(sq[15:8], 1'b0, 1'b0);
            owe(sq[7:0], 1'b0, 1'b0);
            owe(cur_ts[31:24], 1'b0, 1'b0);
            owe(cur_ts[23:16], 1'b0, 1'b0);
            owe(cur_ts[15:8], 1'b0, 1'b0);
            owe(cur_ts[7:0], 1'b0, 1'b0);
            owe(ssrc[31:24], 1'b0, 1'b0);
            owe(ssrc[23:16], 1'b0, 1'b0);
            owe(ssrc[15:8], 1'b0, 1'b0);
            owe(ssrc[7:0], 1'b0, 1'b0);
        endfunction

        function void take_nal_byte(logic [7:0] b, logic first, logic [15:0] len);
            logic [15:0] n;
            logic [15:0] fmax;
            logic [15:0] size;
            logic [7:0]  fuh;
            // NAL header byte: start a new unit and drop any unit in progress
            if (first)
            begin
                n = (len == 16'd0) ? 16'd1 : len;
                cur_ts = cur_ts + ts_step;
                frag_left = '0;
                payload_left = n - 16'd1;
                if (n <= single_max)
                begin
                    frag_mode = 1'b0;
                    first_frag = 1'b0;
                    owe_header(1'b1);
                    owe(b, 1'b0, payload_left == 16'd0);
                end
                else
                begin
                    frag_mode = 1'b1;
                    nal_hdr = b;
                    first_frag = 1'b1;
                end
                return;
            end
            // Stray byte with no unit open
            if (payload_left == 16'd0)
                return;
            if (!frag_mode)
            begin
                payload_left = payload_left - 16'd1;
                owe(b, 1'b0, payload_left == 16'd0);
                return;
            end
            // Open a new FU-A fragment
            if (frag_left == 16'd0)
            begin
                fmax = (frag_max == 16'd0) ? 16'd1 : frag_max;
                size = (payload_left < fmax) ? payload_left : fmax;
                fuh = {3'b000, nal_hdr[4:0]};
                if (first_frag)
                    fuh = fuh | FU_S_FLAG;
                else if (size == payload_left)
                    fuh = fuh | FU_E_FLAG;
                owe_header(1'b0);
                owe((nal_hdr & FU_NRI_MASK) | FU_A_TYPE, 1'b0, 1'b0);
                owe(fuh, 1'b0, 1'b0);
                first_frag = 1'b0;
                frag_left = size;
            end
            frag_left = frag_left - 16'd1;
            payload_left = payload_left - 16'd1;
            owe(b, 1'b0, frag_left == 16'd0);
        endfunction

        task report(string what, logic [7:0] got, logic [7:0] want);
            fails++;
            $display("mismatch at %0t: %s got %02h want %02h", $realtime, what, got, want);
        endtask

        task match_packet_byte(logic [7:0] d, logic s, logic e);
            pkt_byte_t w;
            if (owed.size() == 0)
            begin
                report("packet byte with nothing owed", d, 8'h00);
                return;
            end
            w = owed.pop_front();
            if (d !== w.data)
                report("packet_byte", d, w.data);
            if (s !== w.sop)
                report("packet_start", {7'd0, s}, {7'd0, w.sop});
            if (e !== w.eop)
                report("packet_end", {7'd0, e}, {7'd0, w.eop});
        endtask

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  nal_byte;
    logic        nal_first;
    logic [15:0] nal_length;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  packet_byte;
    logic        packet_start;
    logic        packet_end;

    rtp_packet_tracker tracker = new();

    int snd_idle_pct = 36;
    int rcv_idle_pct = 57;
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    rtp_h264_nal_packetizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .nal_byte     (nal_byte),
        .nal_first    (nal_first),
        .nal_length   (nal_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .packet_byte  (packet_byte),
        .packet_start (packet_start),
        .packet_end   (packet_end)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Abort when no transaction moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receive packet bytes, stall at random, hold off on request
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                tracker.match_packet_byte(packet_byte, packet_start, packet_end);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Offer one NAL byte and hold it until the transaction completes
    task automatic send_byte(input logic [7:0] b, input logic first, input logic [15:0] len);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        nal_byte   <= b;
        nal_first  <= first;
        nal_length <= len;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.take_nal_byte(b, first, len);
    endtask

    // Send a NAL header carrying len_field, then count - 1 body bytes
    task automatic send_nal(input logic [15:0] len_field, input int count);
        send_byte(8'($urandom), 1'b1, len_field);
        for (int i = 1; i < count; i++)
            send_byte(8'($urandom), 1'b0, 16'($urandom));
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        tracker.write_reg(idx, val);
    endtask

    // Drain the block, let it settle, then rewrite every register
    task automatic apply_config(input logic [31:0] ssrc, input logic [31:0] seq,
                                input logic [31:0] ts, input logic [31:0] step,
                                input logic [31:0] smax, input logic [31:0] fmax);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write(REG_SSRC, ssrc);
        cfg_write(REG_START_SEQ, seq);
        cfg_write(REG_START_TS, ts);
        cfg_write(REG_TS_STEP, step);
        cfg_write(REG_SINGLE_MAX, smax);
        cfg_write(REG_FRAG_MAX, fmax);
        cfg_write(REG_SPARE_A, $urandom);
        cfg_write(REG_SPARE_B, $urandom);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed NAL units, some abandoned ones and stray bytes
    task automatic run_phase(input int snd_pct, input int rcv_pct, input int smax_hi,
                             input int fmax_hi, input bit hold);
        int done;
        int pick;
        int len;
        int cnt;
        done = 0;
        apply_config($urandom, $urandom, $urandom, $urandom,
                     $urandom_range(1, smax_hi), $urandom_range(0, fmax_hi));
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        hold_request = hold;
        while (done < PHASE_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                len = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 24);
                cnt = (len == 0) ? 1 : len;
                send_nal(16'(len), cnt);
                done += cnt;
            end
            else if (pick < 92)
            begin
                len = $urandom_range(0, 65535);
                cnt = $urandom_range(1, 5);
                send_nal(16'(len), cnt);
                done += cnt;
            end
            else
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 16'($urandom));
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= REG_SSRC;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        nal_byte   <= '0;
        nal_first  <= 1'b0;
        nal_length <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: short single packet
        send_nal(16'd3, 3);

        // Counters at wrap, one-byte fragments from a zero fragment size
        apply_config(32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd4, 32'd0);
        send_byte(8'h00, 1'b1, 16'd1);
        send_byte(8'hFF, 1'b1, 16'd0);
        send_nal(16'd3, 3);
        send_byte(8'($urandom), 1'b0, 16'hFFFF);
        send_nal(16'd6, 6);
        send_nal(16'd5, 2);

        // Nothing fits a single packet: empty unit, lone fragment, abandoned unit
        apply_config(32'h0, 32'h0, 32'h0, 32'd0, 32'd0, 32'h0000_FFFF);
        send_nal(16'd1, 1);
        send_nal(16'd3, 3);
        send_nal(16'hFFFF, 2);

        // Largest single packet, left without its end mark
        apply_config($urandom, $urandom, $urandom, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'd1);
        send_nal(16'hFFFF, 2);

        run_phase(36, 57, 16, 6, 1'b1);
        run_phase(57, 36, 3, 3, 1'b0);
        run_phase(0, 0, 40, 12, 1'b0);

        // Drain and finish
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.fails == 0 && tracker.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
